[design/energy_binned_pixel_histogram_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the energy binned pixel histogram
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ENERGY_BINNED_PIXEL_HISTOGRAM_TOP_ASSERT_SVH
`define ENERGY_BINNED_PIXEL_HISTOGRAM_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Condition implies a property in the same cycle
`define EBPH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition implies a property in the next cycle
`define EBPH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define EBPH_ASSERT(label, clk, rst_n, prop, msg)
`define EBPH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

[design/ebph_pkg.sv]
// ----------------------------------------------------------------------------
// ebph_pkg
// Shared sizes, codes and types of the energy binned pixel histogram.
// ----------------------------------------------------------------------------
package ebph_pkg;

	// Image geometry
	localparam int ENERGY_BINS  = 16;
	localparam int IMAGE_WIDTH  = 64;
	localparam int IMAGE_HEIGHT = 64;
	localparam int CELLS        = ENERGY_BINS * IMAGE_WIDTH * IMAGE_HEIGHT;

	localparam int BIN_W  = $clog2(ENERGY_BINS);
	localparam int COL_W  = $clog2(IMAGE_WIDTH);
	localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
	localparam int ADDR_W = $clog2(CELLS);

	// Field widths
	localparam int ENERGY_W  = 24;
	localparam int POS_W     = 24;
	localparam int SCALE_W   = 32;
	localparam int WEIGHT_W  = 32;
	localparam int SUM_W     = 48;
	localparam int EPROD_W   = ENERGY_W + SCALE_W;
	localparam int PIX_W     = POS_W + SCALE_W + 1;
	localparam int FRAC_BITS = 16;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ENERGY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENERGY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EBIN_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd4;

	// Input kinds
	localparam logic [1:0] KIND_HIT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Result status codes
	localparam logic [2:0] STATUS_ACCUM      = 3'd0;
	localparam logic [2:0] STATUS_NOT_PHOTON = 3'd1;
	localparam logic [2:0] STATUS_ENERGY     = 3'd2;
	localparam logic [2:0] STATUS_OUTSIDE    = 3'd3;
	localparam logic [2:0] STATUS_DONE       = 3'd4;

	// Back-end operations
	localparam logic [1:0] OP_NOTE  = 2'd0;
	localparam logic [1:0] OP_ACC   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Classified work handed from front to back
	typedef struct packed {
		logic [1:0]          op;
		logic                taken;
		logic [2:0]          status;
		logic [ADDR_W-1:0]   addr;
		logic [WEIGHT_W-1:0] beta_w;
		logic [WEIGHT_W-1:0] delta_w;
	} job_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One result word
	typedef struct packed {
		logic             taken;
		logic [2:0]       status;
		logic [SUM_W-1:0] beta;
		logic [SUM_W-1:0] delta;
	} result_t;

endpackage

[design/ebph_front.sv]
// ----------------------------------------------------------------------------
// ebph_front
// Holds configuration, accepts input words, scales energy and position and
// classifies each word into a back-end job.
// ----------------------------------------------------------------------------
module ebph_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ebph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ebph_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic                                is_photon,
	input  logic [ebph_pkg::ENERGY_W-1:0]       energy,
	input  logic signed [ebph_pkg::POS_W-1:0]   pos_x,
	input  logic signed [ebph_pkg::POS_W-1:0]   pos_y,
	input  logic [ebph_pkg::WEIGHT_W-1:0]       beta_weight,
	input  logic [ebph_pkg::WEIGHT_W-1:0]       delta_weight,
	input  logic [3:0]                          read_bin,
	input  logic [5:0]                          read_col,
	input  logic [5:0]                          read_row,
	input  logic                                init_busy,
	input  ebph_pkg::q_stat_t                   q_st,
	output logic                                q_push,
	output ebph_pkg::job_t                      q_job
);

	localparam logic signed [ebph_pkg::PIX_W-1:0] FRAC_ONE =
		ebph_pkg::PIX_W'(1 << ebph_pkg::FRAC_BITS);
	localparam logic signed [ebph_pkg::PIX_W-1:0] X_OFS =
		ebph_pkg::PIX_W'((ebph_pkg::IMAGE_WIDTH / 2) << ebph_pkg::FRAC_BITS);
	localparam logic signed [ebph_pkg::PIX_W-1:0] X_END =
		ebph_pkg::PIX_W'(ebph_pkg::IMAGE_WIDTH << ebph_pkg::FRAC_BITS);
	localparam logic signed [ebph_pkg::PIX_W-1:0] Y_OFS =
		ebph_pkg::PIX_W'((ebph_pkg::IMAGE_HEIGHT / 2) << ebph_pkg::FRAC_BITS);
	localparam logic signed [ebph_pkg::PIX_W-1:0] Y_END =
		ebph_pkg::PIX_W'(ebph_pkg::IMAGE_HEIGHT << ebph_pkg::FRAC_BITS);

	// Linear cell address from bin, column and row
	function automatic logic [ebph_pkg::ADDR_W-1:0] cell_addr(
		input logic [ebph_pkg::BIN_W-1:0] b,
		input logic [ebph_pkg::COL_W-1:0] c,
		input logic [ebph_pkg::ROW_W-1:0] r
	);
		logic [ebph_pkg::ADDR_W-1:0] bc;
		bc = ebph_pkg::ADDR_W'(b) * ebph_pkg::ADDR_W'(ebph_pkg::IMAGE_WIDTH)
			+ ebph_pkg::ADDR_W'(c);
		return bc * ebph_pkg::ADDR_W'(ebph_pkg::IMAGE_HEIGHT) + ebph_pkg::ADDR_W'(r);
	endfunction

	// Configuration registers
	logic [ebph_pkg::ENERGY_W-1:0] min_energy_q;
	logic [ebph_pkg::ENERGY_W-1:0] max_energy_q;
	logic [ebph_pkg::SCALE_W-1:0]  ebin_scale_q;
	logic [ebph_pkg::SCALE_W-1:0]  x_scale_q;
	logic [ebph_pkg::SCALE_W-1:0]  y_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_energy_q <= '0;
			max_energy_q <= '1;
			ebin_scale_q <= '0;
			x_scale_q    <= ebph_pkg::SCALE_W'(1 << ebph_pkg::FRAC_BITS);
			y_scale_q    <= ebph_pkg::SCALE_W'(1 << ebph_pkg::FRAC_BITS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ebph_pkg::REG_MIN_ENERGY: min_energy_q <= cfg_data[ebph_pkg::ENERGY_W-1:0];
				ebph_pkg::REG_MAX_ENERGY: max_energy_q <= cfg_data[ebph_pkg::ENERGY_W-1:0];
				ebph_pkg::REG_EBIN_SCALE: ebin_scale_q <= cfg_data;
				ebph_pkg::REG_X_SCALE:    x_scale_q    <= cfg_data;
				ebph_pkg::REG_Y_SCALE:    y_scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept when the stage register can move on
	logic in_take;
	logic v_s1;

	assign in_stall = init_busy || (v_s1 && q_st.full);
	assign in_take  = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_st.full;

	// Window check and products ahead of the stage register
	logic                                win_ok;
	logic [ebph_pkg::ENERGY_W-1:0]       e_diff;
	logic [ebph_pkg::EPROD_W-1:0]        eprod_c;
	logic signed [ebph_pkg::PIX_W-1:0]   xprod_c;
	logic signed [ebph_pkg::PIX_W-1:0]   yprod_c;

	always_comb begin
		win_ok  = (energy != '0) && (energy <= max_energy_q) && (energy >= min_energy_q);
		e_diff  = energy - min_energy_q;
		eprod_c = ebph_pkg::EPROD_W'(e_diff) * ebph_pkg::EPROD_W'(ebin_scale_q);
		xprod_c = ebph_pkg::PIX_W'(pos_x) * $signed(ebph_pkg::PIX_W'({1'b0, x_scale_q}));
		yprod_c = ebph_pkg::PIX_W'(pos_y) * $signed(ebph_pkg::PIX_W'({1'b0, y_scale_q}));
	end

	// Stage one registers
	logic [1:0]                          kind_s1;
	logic                                photon_s1;
	logic                                win_s1;
	logic [ebph_pkg::EPROD_W-1:0]        eprod_s1;
	logic signed [ebph_pkg::PIX_W-1:0]   xprod_s1;
	logic signed [ebph_pkg::PIX_W-1:0]   yprod_s1;
	logic [ebph_pkg::WEIGHT_W-1:0]       bw_s1;
	logic [ebph_pkg::WEIGHT_W-1:0]       dw_s1;
	logic [3:0]                          rbin_s1;
	logic [5:0]                          rcol_s1;
	logic [5:0]                          rrow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1   <= kind;
			photon_s1 <= is_photon;
			win_s1    <= win_ok;
			eprod_s1  <= eprod_c;
			xprod_s1  <= xprod_c;
			yprod_s1  <= yprod_c;
			bw_s1     <= beta_weight;
			dw_s1     <= delta_weight;
			rbin_s1   <= read_bin;
			rcol_s1   <= read_col;
			rrow_s1   <= read_row;
		end
	end

	// Bin, column and row with their range checks
	logic [ebph_pkg::ENERGY_W-1:0]       bin_hi;
	logic                                bin_ok;
	logic signed [ebph_pkg::PIX_W-1:0]   xsum;
	logic signed [ebph_pkg::PIX_W-1:0]   ysum;
	logic                                col_ok;
	logic                                row_ok;
	logic [ebph_pkg::COL_W-1:0]          col_idx;
	logic [ebph_pkg::ROW_W-1:0]          row_idx;
	logic                                rd_ok;

	always_comb begin
		bin_hi  = eprod_s1[ebph_pkg::EPROD_W-1 -: ebph_pkg::ENERGY_W];
		bin_ok  = bin_hi < ebph_pkg::ENERGY_W'(ebph_pkg::ENERGY_BINS);
		xsum    = xprod_s1 + X_OFS;
		ysum    = yprod_s1 + Y_OFS;
		// a sum between minus one and zero truncates to index zero
		col_ok  = (xsum > -FRAC_ONE) && (xsum < X_END);
		row_ok  = (ysum > -FRAC_ONE) && (ysum < Y_END);
		col_idx = xsum[ebph_pkg::PIX_W-1] ? '0 : xsum[ebph_pkg::FRAC_BITS +: ebph_pkg::COL_W];
		row_idx = ysum[ebph_pkg::PIX_W-1] ? '0 : ysum[ebph_pkg::FRAC_BITS +: ebph_pkg::ROW_W];
		rd_ok   = (32'(rbin_s1) < ebph_pkg::ENERGY_BINS)
			&& (32'(rcol_s1) < ebph_pkg::IMAGE_WIDTH)
			&& (32'(rrow_s1) < ebph_pkg::IMAGE_HEIGHT);
	end

	// Classify into a job
	always_comb begin
		q_job.op      = ebph_pkg::OP_NOTE;
		q_job.taken   = 1'b1;
		q_job.status  = ebph_pkg::STATUS_DONE;
		q_job.addr    = '0;
		q_job.beta_w  = bw_s1;
		q_job.delta_w = dw_s1;
		unique case (kind_s1)
			ebph_pkg::KIND_HIT: begin
				if (!photon_s1) begin
					q_job.status = ebph_pkg::STATUS_NOT_PHOTON;
				end else if (!win_s1) begin
					q_job.taken  = 1'b0;
					q_job.status = ebph_pkg::STATUS_ENERGY;
				end else if (!(bin_ok && col_ok && row_ok)) begin
					q_job.taken  = 1'b0;
					q_job.status = ebph_pkg::STATUS_OUTSIDE;
				end else begin
					q_job.op     = ebph_pkg::OP_ACC;
					q_job.status = ebph_pkg::STATUS_ACCUM;
					q_job.addr   = cell_addr(bin_hi[ebph_pkg::BIN_W-1:0], col_idx, row_idx);
				end
			end
			ebph_pkg::KIND_READ: begin
				if (rd_ok) begin
					q_job.op   = ebph_pkg::OP_READ;
					q_job.addr = cell_addr(ebph_pkg::BIN_W'(rbin_s1),
						ebph_pkg::COL_W'(rcol_s1), ebph_pkg::ROW_W'(rrow_s1));
				end
			end
			ebph_pkg::KIND_CLEAR: begin
				q_job.op = ebph_pkg::OP_CLEAR;
			end
			default: ;
		endcase
	end

endmodule

[design/ebph_queue.sv]
// ----------------------------------------------------------------------------
// ebph_queue
// Short job queue between the classifying front and the memory back end.
// ----------------------------------------------------------------------------
module ebph_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ebph_pkg::job_t    push_job,
	input  logic              pop,
	output ebph_pkg::job_t    head,
	output ebph_pkg::q_stat_t q_st
);

	localparam logic [ebph_pkg::QPTR_W-1:0] LAST_PTR =
		ebph_pkg::QPTR_W'(ebph_pkg::QUEUE_DEPTH - 1);

	ebph_pkg::job_t                entries_q [ebph_pkg::QUEUE_DEPTH];
	logic [ebph_pkg::QPTR_W-1:0]   wr_q;
	logic [ebph_pkg::QPTR_W-1:0]   rd_q;
	logic [ebph_pkg::QPTR_W:0]     cnt_q;

	assign head       = entries_q[rd_q];
	assign q_st.empty = (cnt_q == '0);
	assign q_st.full  = (cnt_q == (ebph_pkg::QPTR_W + 1)'(ebph_pkg::QUEUE_DEPTH));

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_job;
		end
	end

endmodule

[design/ebph_back.sv]
// ----------------------------------------------------------------------------
// ebph_back
// Runs queued jobs against the accumulator memory: read-modify-write for
// hits, cell reads, clearing sweeps, and the result register.
// ----------------------------------------------------------------------------
`include "energy_binned_pixel_histogram_top_assert.svh"

module ebph_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ebph_pkg::job_t                  head,
	input  ebph_pkg::q_stat_t               q_st,
	output logic                            q_pop,
	output logic                            init_busy,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit_taken,
	output logic [2:0]                      status,
	output logic [ebph_pkg::SUM_W-1:0]      beta_sum,
	output logic [ebph_pkg::SUM_W-1:0]      delta_sum
);

	localparam int MEM_W = 2 * ebph_pkg::SUM_W;
	localparam logic [ebph_pkg::ADDR_W-1:0] LAST_ADDR = ebph_pkg::ADDR_W'(ebph_pkg::CELLS - 1);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	// Saturating add of a weight to a sum
	function automatic logic [ebph_pkg::SUM_W-1:0] sat_add(
		input logic [ebph_pkg::SUM_W-1:0]    a,
		input logic [ebph_pkg::WEIGHT_W-1:0] w
	);
		logic [ebph_pkg::SUM_W:0] s;
		s = {1'b0, a} + (ebph_pkg::SUM_W + 1)'(w);
		return s[ebph_pkg::SUM_W] ? '1 : s[ebph_pkg::SUM_W-1:0];
	endfunction

	logic [1:0]                     state_q;
	logic [1:0]                     state_d;
	ebph_pkg::job_t                 cur_q;
	logic [ebph_pkg::ADDR_W-1:0]    clr_q;
	logic                           clr_last;
	logic                           out_valid_q;
	logic                           out_free;
	logic                           load_res;
	ebph_pkg::result_t              res_q;
	ebph_pkg::result_t              res_d;

	// Accumulator memory: beta in the upper half, delta in the lower half
	logic [MEM_W-1:0]               image_q [ebph_pkg::CELLS];
	logic [MEM_W-1:0]               rd_data_q;
	logic                           mem_we;
	logic [ebph_pkg::ADDR_W-1:0]    mem_wa;
	logic [MEM_W-1:0]               mem_wd;
	logic [ebph_pkg::ADDR_W-1:0]    mem_ra;
	logic [ebph_pkg::SUM_W-1:0]     rd_beta;
	logic [ebph_pkg::SUM_W-1:0]     rd_delta;

	assign init_busy = (state_q == ST_INIT);
	assign out_free  = !out_valid_q || !out_stall;
	assign clr_last  = (clr_q == LAST_ADDR);
	assign rd_beta   = rd_data_q[MEM_W-1 -: ebph_pkg::SUM_W];
	assign rd_delta  = rd_data_q[ebph_pkg::SUM_W-1:0];
	assign mem_ra    = (state_q == ST_DATA) ? cur_q.addr : head.addr;

	// Sequence jobs
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = clr_q;
		mem_wd   = '0;
		load_res = 1'b0;
		res_d    = '{taken: cur_q.taken, status: cur_q.status, beta: '0, delta: '0};
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				res_d = '{taken: head.taken, status: head.status, beta: '0, delta: '0};
				if (!q_st.empty) begin
					unique case (head.op)
						ebph_pkg::OP_NOTE: begin
							if (out_free) begin
								q_pop    = 1'b1;
								load_res = 1'b1;
							end
						end
						ebph_pkg::OP_ACC, ebph_pkg::OP_READ: begin
							q_pop   = 1'b1;
							state_d = ST_DATA;
						end
						ebph_pkg::OP_CLEAR: begin
							q_pop   = 1'b1;
							state_d = ST_CLEAR;
						end
					endcase
				end
			end
			ST_DATA: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
					if (cur_q.op == ebph_pkg::OP_ACC) begin
						mem_we = 1'b1;
						mem_wa = cur_q.addr;
						mem_wd = {sat_add(rd_beta, cur_q.beta_w), sat_add(rd_delta, cur_q.delta_w)};
					end else begin
						res_d.beta  = rd_beta;
						res_d.delta = rd_delta;
					end
				end
			end
			ST_CLEAR: begin
				// keep rewriting the last cell while the result waits
				mem_we = 1'b1;
				if (clr_last && out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				clr_q <= '0;
			end else if ((state_q == ST_INIT || state_q == ST_CLEAR) && !clr_last) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold current job and result word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	// Memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			image_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= image_q[mem_ra];
	end

	assign out_valid = out_valid_q;
	assign hit_taken = res_q.taken;
	assign status    = res_q.status;
	assign beta_sum  = res_q.beta;
	assign delta_sum = res_q.delta;

	`EBPH_ASSERT(a_pop_nonempty, clk, arst_n, q_pop |-> !q_st.empty, "pop from empty queue")
	`EBPH_ASSERT(a_init_quiet, clk, arst_n, (state_q == ST_INIT) |-> (!out_valid_q && !q_pop), "activity during init sweep")
	`EBPH_ASSERT(a_write_source, clk, arst_n, (mem_we && state_q == ST_DATA) |-> (cur_q.op == ebph_pkg::OP_ACC), "data write without accumulate job")
	`EBPH_ASSERT_NEXT(a_clear_start, clk, arst_n, q_pop && head.op == ebph_pkg::OP_CLEAR, state_q == ST_CLEAR && clr_q == '0, "clear job did not start sweep")

endmodule

[design/energy_binned_pixel_histogram_top.sv]
// ----------------------------------------------------------------------------
// energy_binned_pixel_histogram_top
// Energy resolved pixel histogram: classifies detector hits and accumulates
// two weights per energy bin, column and row in a cell memory.
// ----------------------------------------------------------------------------
// From input accept to result valid a word passes the stage register, a queue
// entry and the result register; hits that accumulate and cell reads also pass
// the registered memory read. 1 word per cycle for non-memory words while no
// stall holds them; accumulate and read (registered read then write on the one
// memory port) end before the back end takes the next job, as does a clear of
// all CELLS cells. After reset every cell is cleared with in_stall held high.
module energy_binned_pixel_histogram_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ebph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ebph_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic                                is_photon,
	input  logic [ebph_pkg::ENERGY_W-1:0]       energy,
	input  logic signed [ebph_pkg::POS_W-1:0]   pos_x,
	input  logic signed [ebph_pkg::POS_W-1:0]   pos_y,
	input  logic [ebph_pkg::WEIGHT_W-1:0]       beta_weight,
	input  logic [ebph_pkg::WEIGHT_W-1:0]       delta_weight,
	input  logic [3:0]                          read_bin,
	input  logic [5:0]                          read_col,
	input  logic [5:0]                          read_row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit_taken,
	output logic [2:0]                          status,
	output logic [ebph_pkg::SUM_W-1:0]          beta_sum,
	output logic [ebph_pkg::SUM_W-1:0]          delta_sum
);

	logic              init_busy;
	logic              q_push;
	logic              q_pop;
	ebph_pkg::job_t    q_job;
	ebph_pkg::job_t    q_head;
	ebph_pkg::q_stat_t q_st;

	// Classify input words
	ebph_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.is_photon    (is_photon),
		.energy       (energy),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.beta_weight  (beta_weight),
		.delta_weight (delta_weight),
		.read_bin     (read_bin),
		.read_col     (read_col),
		.read_row     (read_row),
		.init_busy    (init_busy),
		.q_st         (q_st),
		.q_push       (q_push),
		.q_job        (q_job)
	);

	// Decouple front and back
	ebph_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.q_st     (q_st)
	);

	// Execute jobs against the memory
	ebph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_st      (q_st),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit_taken (hit_taken),
		.status    (status),
		.beta_sum  (beta_sum),
		.delta_sum (delta_sum)
	);

endmodule
